>>> rtl/disi_pkg.sv
// Shared constants, widths, the controller state type and the table control struct for the interval table.
// Depends on nothing; used by disi_table and disjoint_interval_split_insert_core.
package disi_pkg;
    localparam int MAX_INTERVALS = 64;
    localparam int CODE_BITS     = 16;
    localparam int IDX_W         = $clog2(MAX_INTERVALS);
    localparam int CNT_W         = $clog2(MAX_INTERVALS + 1);
    localparam int ENTRY_W       = 2 * CODE_BITS;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_READ   = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD,
        ST_LOAD,
        ST_EMIT,
        ST_TAIL,
        ST_READ_ISSUE,
        ST_READ_DATA,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic             rd_en;
        logic             rd_bank;
        logic [IDX_W-1:0] rd_idx;
        logic             wr_en;
        logic             wr_bank;
        logic [IDX_W-1:0] wr_idx;
    } tbl_ctl_t;
endpackage

>>> rtl/disi_table.sv
// Two-bank interval store: one synchronous read port, one write port.
// Depends on disi_pkg.
module disi_table (
    input  logic                       clk,
    input  disi_pkg::tbl_ctl_t         ctl,
    input  logic [disi_pkg::ENTRY_W-1:0] wr_data,
    output logic [disi_pkg::ENTRY_W-1:0] rd_data
);
    logic [disi_pkg::ENTRY_W-1:0] mem [2*disi_pkg::MAX_INTERVALS];

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[{ctl.wr_bank, ctl.wr_idx}] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_data <= mem[{ctl.rd_bank, ctl.rd_idx}];
        end
    end
endmodule

>>> rtl/disjoint_interval_split_insert_core.sv
// Disjoint interval split-insert table: top level. Uses disi_pkg, disi_table.
// Read item: accept, then ST_READ_ISSUE, ST_READ_DATA and the ST_RESP result strobe. Insert item:
// ST_RD and ST_LOAD for each stored interval plus an ST_EMIT step for each piece emitted from it,
// then ST_TAIL and ST_RESP; an empty range goes straight from accept to ST_RESP.
// The table has a single read port and one piece is written per cycle. One item at a time.
// Reset (async, active low) empties the table at once: count goes to zero, bank 0 active.
// Results are strobed for one cycle and cannot be stalled.
module disjoint_interval_split_insert_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        opcode,
    input  logic [15:0] range_first,
    input  logic [15:0] range_last,
    input  logic [5:0]  read_index,
    output logic        result_valid,
    output logic [15:0] entry_first,
    output logic [15:0] entry_last,
    output logic        entry_valid,
    output logic [6:0]  interval_count,
    output logic        overflow
);
    localparam int CB = disi_pkg::CODE_BITS;
    localparam int IW = disi_pkg::IDX_W;
    localparam int CW = disi_pkg::CNT_W;

    disi_pkg::state_t state_reg, state_next;

    // Active bank holds the live table; inserts build the refined table in the other bank
    // and flip banks only when the result fits, so a rejected insert costs nothing.
    logic          bank_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] idx_reg;      // stored interval being walked
    logic [CW-1:0] new_n_reg;    // pieces written to the shadow bank
    logic          full_reg;
    logic [CB:0]   cur_reg;      // next uncovered point of the range, may reach 2^CB
    logic [CB-1:0] lim_reg;      // range last
    logic [CB-1:0] a_reg, b_reg; // current stored interval (a moves when split)
    logic [5:0]    ridx_reg;

    logic [15:0] ef_reg, el_reg;
    logic        ev_reg, ov_reg;

    disi_pkg::tbl_ctl_t           ctl;
    logic [disi_pkg::ENTRY_W-1:0] rd_data;
    logic [disi_pkg::ENTRY_W-1:0] wr_data;

    disi_table u_table (
        .clk     (clk),
        .ctl     (ctl),
        .wr_data (wr_data),
        .rd_data (rd_data)
    );

    // Piece selection: one emitted interval per cycle in ST_EMIT, and the final piece in ST_TAIL.
    logic [CB:0]   a_x, b_x, l_x;
    logic          active;
    logic          emit_v;
    logic [CB-1:0] w_lo, w_hi;
    logic [CB:0]   cur_n;
    logic [CB-1:0] a_n;
    logic          advance;
    logic [CB:0]   e_val;

    assign a_x = {1'b0, a_reg};
    assign b_x = {1'b0, b_reg};
    assign l_x = {1'b0, lim_reg};
    assign active = (cur_reg <= l_x) && (b_x >= cur_reg);

    always_comb
    begin
        emit_v  = 1'b0;
        w_lo    = a_reg;
        w_hi    = b_reg;
        cur_n   = cur_reg;
        a_n     = a_reg;
        advance = 1'b0;
        e_val   = l_x;
        if (state_reg == disi_pkg::ST_EMIT)
        begin
            emit_v = 1'b1;
            priority if (!active)
            begin
                advance = 1'b1;
            end
            else if (cur_reg < a_x)
            begin
                // gap before the stored interval
                e_val = (l_x < a_x - 1'b1) ? l_x : a_x - 1'b1;
                w_lo  = cur_reg[CB-1:0];
                w_hi  = e_val[CB-1:0];
                cur_n = e_val + 1'b1;
            end
            else if (cur_reg > a_x)
            begin
                // left part outside the range
                w_lo = a_reg;
                w_hi = CB'(cur_reg - 1'b1);
                a_n  = cur_reg[CB-1:0];
            end
            else
            begin
                e_val = (l_x < b_x) ? l_x : b_x;
                w_lo  = cur_reg[CB-1:0];
                w_hi  = e_val[CB-1:0];
                cur_n = e_val + 1'b1;
                if (l_x < b_x)
                begin
                    // right part revisited as an inactive remainder
                    a_n = CB'(l_x + 1'b1);
                end
                else
                begin
                    advance = 1'b1;
                end
            end
        end
        else if (state_reg == disi_pkg::ST_TAIL && cur_reg <= l_x)
        begin
            emit_v = 1'b1;
            w_lo   = cur_reg[CB-1:0];
            w_hi   = lim_reg;
        end
    end

    logic room;
    assign room    = (new_n_reg != CW'(disi_pkg::MAX_INTERVALS));
    assign wr_data = {w_lo, w_hi};

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            disi_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    if (opcode == disi_pkg::OP_READ)
                        state_next = disi_pkg::ST_READ_ISSUE;
                    else if (range_last < range_first)
                        state_next = disi_pkg::ST_RESP;
                    else if (count_reg == '0)
                        state_next = disi_pkg::ST_TAIL;
                    else
                        state_next = disi_pkg::ST_RD;
                end
            end
            disi_pkg::ST_RD:         state_next = disi_pkg::ST_LOAD;
            disi_pkg::ST_LOAD:       state_next = disi_pkg::ST_EMIT;
            disi_pkg::ST_EMIT:
            begin
                if (advance)
                    state_next = (idx_reg + 1'b1 == count_reg) ? disi_pkg::ST_TAIL
                                                               : disi_pkg::ST_RD;
            end
            disi_pkg::ST_TAIL:       state_next = disi_pkg::ST_RESP;
            disi_pkg::ST_READ_ISSUE: state_next = disi_pkg::ST_READ_DATA;
            disi_pkg::ST_READ_DATA:  state_next = disi_pkg::ST_RESP;
            disi_pkg::ST_RESP:       state_next = disi_pkg::ST_IDLE;
            default:                 state_next = disi_pkg::ST_IDLE;
        endcase
    end

    // Outputs and table control
    always_comb
    begin
        busy         = (state_reg != disi_pkg::ST_IDLE);
        result_valid = (state_reg == disi_pkg::ST_RESP);
        ctl.rd_en    = (state_reg == disi_pkg::ST_RD) || (state_reg == disi_pkg::ST_READ_ISSUE);
        ctl.rd_bank  = bank_reg;
        ctl.rd_idx   = (state_reg == disi_pkg::ST_READ_ISSUE) ? IW'(ridx_reg)
                                                              : idx_reg[IW-1:0];
        ctl.wr_en    = emit_v && room;
        ctl.wr_bank  = ~bank_reg;
        ctl.wr_idx   = new_n_reg[IW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= disi_pkg::ST_IDLE;
            bank_reg  <= 1'b0;
            count_reg <= '0;
            idx_reg   <= '0;
            new_n_reg <= '0;
            full_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                disi_pkg::ST_IDLE:
                begin
                    idx_reg   <= '0;
                    new_n_reg <= '0;
                    full_reg  <= 1'b0;
                end
                disi_pkg::ST_EMIT:
                begin
                    if (advance)
                        idx_reg <= idx_reg + 1'b1;
                end
                disi_pkg::ST_TAIL:
                begin
                    if (!(full_reg || (emit_v && !room)))
                    begin
                        bank_reg  <= ~bank_reg;
                        count_reg <= new_n_reg + CW'(emit_v);
                    end
                end
                default:
                begin
                end
            endcase
            if (emit_v)
            begin
                if (room)
                    new_n_reg <= new_n_reg + 1'b1;
                else
                    full_reg <= 1'b1;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            disi_pkg::ST_IDLE:
            begin
                cur_reg  <= {1'b0, range_first};
                lim_reg  <= range_last;
                ridx_reg <= read_index;
                ef_reg   <= '0;
                el_reg   <= '0;
                ev_reg   <= 1'b0;
                ov_reg   <= 1'b0;
            end
            disi_pkg::ST_LOAD:
            begin
                a_reg <= rd_data[disi_pkg::ENTRY_W-1:CB];
                b_reg <= rd_data[CB-1:0];
            end
            disi_pkg::ST_EMIT:
            begin
                cur_reg <= cur_n;
                a_reg   <= a_n;
            end
            disi_pkg::ST_TAIL:
            begin
                ov_reg <= full_reg || (emit_v && !room);
            end
            disi_pkg::ST_READ_ISSUE:
            begin
                ev_reg <= ({1'b0, ridx_reg} < count_reg);
            end
            disi_pkg::ST_READ_DATA:
            begin
                if (ev_reg)
                begin
                    ef_reg <= rd_data[disi_pkg::ENTRY_W-1:CB];
                    el_reg <= rd_data[CB-1:0];
                end
            end
            default:
            begin
            end
        endcase
    end

    assign entry_first    = ef_reg;
    assign entry_last     = el_reg;
    assign entry_valid    = ev_reg;
    assign overflow       = ov_reg;
    assign interval_count = count_reg;

    // Count never exceeds capacity.
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(disi_pkg::MAX_INTERVALS))
        else $error("interval count above capacity");

    // A result never reports both a valid read and an overflow.
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(entry_valid && overflow))
        else $error("read and overflow flagged together");

    // A rejected insert leaves the count unchanged.
    a_rej: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && overflow) |-> $stable(count_reg))
        else $error("count changed on rejected insert");

    // Shadow bank writes never happen while walking a read item.
    a_wr: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.wr_en |-> (state_reg == disi_pkg::ST_EMIT || state_reg == disi_pkg::ST_TAIL))
        else $error("table write outside insert");
endmodule

>>> verif/tb_top.sv
// Self-checking testbench for disjoint_interval_split_insert_core.
// Depends on disi_pkg and the core RTL; a local predictor tracks the interval table.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 2000000;

    typedef struct {
        logic        op;
        logic [15:0] first;
        logic [15:0] last;
        logic [5:0]  idx;
    } cmd_t;

    typedef struct {
        logic [15:0] ef;
        logic [15:0] el;
        logic        ev;
        logic [6:0]  cnt;
        logic        ov;
    } resp_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        opcode;
    logic [15:0] range_first;
    logic [15:0] range_last;
    logic [5:0]  read_index;
    logic        result_valid;
    logic [15:0] entry_first;
    logic [15:0] entry_last;
    logic        entry_valid;
    logic [6:0]  interval_count;
    logic        overflow;

    cmd_t  pending_cmds[$];
    resp_t expected_resps[$];
    int    fail_count = 0;
    int    cycle_count = 0;
    int    gap_left;
    int    inserts_seen = 0;
    int    overflows_seen = 0;
    int    reads_seen = 0;

    // Predictor's copy of the table.
    int unsigned tbl_lo[disi_pkg::MAX_INTERVALS];
    int unsigned tbl_hi[disi_pkg::MAX_INTERVALS];
    int unsigned tbl_n = 0;

    disjoint_interval_split_insert_core u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .opcode(opcode), .range_first(range_first), .range_last(range_last),
        .read_index(read_index), .result_valid(result_valid),
        .entry_first(entry_first), .entry_last(entry_last),
        .entry_valid(entry_valid), .interval_count(interval_count),
        .overflow(overflow)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Refine the table by [f, l]; returns 1 when the result would not fit.
    function automatic bit refine_table(int unsigned f, int unsigned l);
        int unsigned nlo[$];
        int unsigned nhi[$];
        int unsigned cur;
        int unsigned a;
        int unsigned b;
        int unsigned e;
        if (l < f)
        begin
            return 1'b0;
        end
        cur = f;
        for (int i = 0; i < tbl_n; i++)
        begin
            a = tbl_lo[i];
            b = tbl_hi[i];
            if (cur <= l && b >= cur)
            begin
                if (cur < a)
                begin
                    e = (l < a - 1) ? l : a - 1;
                    nlo.push_back(cur); nhi.push_back(e);
                    cur = e + 1;
                end
                if (cur <= l)
                begin
                    e = (l < b) ? l : b;
                    if (cur > a)
                    begin
                        nlo.push_back(a); nhi.push_back(cur - 1);
                    end
                    nlo.push_back(cur); nhi.push_back(e);
                    if (l < b)
                    begin
                        nlo.push_back(l + 1); nhi.push_back(b);
                    end
                    cur = e + 1;
                end
                else
                begin
                    nlo.push_back(a); nhi.push_back(b);
                end
            end
            else
            begin
                nlo.push_back(a); nhi.push_back(b);
            end
        end
        if (cur <= l)
        begin
            nlo.push_back(cur); nhi.push_back(l);
        end
        if (nlo.size() > disi_pkg::MAX_INTERVALS)
        begin
            return 1'b1;
        end
        for (int i = 0; i < nlo.size(); i++)
        begin
            tbl_lo[i] = nlo[i];
            tbl_hi[i] = nhi[i];
        end
        tbl_n = nlo.size();
        return 1'b0;
    endfunction

    function automatic resp_t predict_resp(cmd_t c);
        resp_t r;
        r = '{ef: '0, el: '0, ev: 1'b0, cnt: '0, ov: 1'b0};
        if (c.op == disi_pkg::OP_INSERT)
        begin
            r.ov = refine_table(c.first, c.last);
        end
        else if (c.idx < tbl_n)
        begin
            r.ef = 16'(tbl_lo[c.idx]);
            r.el = 16'(tbl_hi[c.idx]);
            r.ev = 1'b1;
        end
        r.cnt = 7'(tbl_n);
        return r;
    endfunction

    task automatic queue_insert(int unsigned f, int unsigned l);
        cmd_t c;
        c.op = disi_pkg::OP_INSERT; c.first = 16'(f); c.last = 16'(l); c.idx = 6'($urandom);
        pending_cmds.push_back(c);
    endtask

    task automatic queue_read(int unsigned idx);
        cmd_t c;
        c.op = disi_pkg::OP_READ; c.first = 16'($urandom); c.last = 16'($urandom);
        c.idx = 6'(idx);
        pending_cmds.push_back(c);
    endtask

    // Driver: one item per accept edge, with random idle bursts until the last 100 items.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            opcode <= disi_pkg::OP_INSERT;
            range_first <= '0;
            range_last <= '0;
            read_index <= '0;
            gap_left <= 0;
        end
        else if (start && busy)
        begin
            // hold the item until taken
        end
        else if (gap_left > 0)
        begin
            start <= 1'b0;
            gap_left <= gap_left - 1;
        end
        else if (pending_cmds.size() > 0)
        begin
            cmd_t c;
            c = pending_cmds.pop_front();
            expected_resps.push_back(predict_resp(c));
            if (c.op == disi_pkg::OP_INSERT)
            begin
                inserts_seen++;
            end
            else
            begin
                reads_seen++;
            end
            start <= 1'b1;
            opcode <= c.op;
            range_first <= c.first;
            range_last <= c.last;
            read_index <= c.idx;
            if (pending_cmds.size() > 100 && $urandom_range(0, 3) == 0)
            begin
                gap_left <= $urandom_range(1, 8);
            end
        end
        else
        begin
            start <= 1'b0;
        end
    end

    // Monitor: compare every strobed result with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (expected_resps.size() == 0)
            begin
                $error("result with no item outstanding");
                fail_count++;
            end
            else
            begin
                resp_t x;
                x = expected_resps.pop_front();
                if (x.ov)
                begin
                    overflows_seen++;
                end
                if (entry_first !== x.ef)
                begin
                    $error("entry_first exp %0h got %0h", x.ef, entry_first);
                    fail_count++;
                end
                if (entry_last !== x.el)
                begin
                    $error("entry_last exp %0h got %0h", x.el, entry_last);
                    fail_count++;
                end
                if (entry_valid !== x.ev)
                begin
                    $error("entry_valid exp %0b got %0b", x.ev, entry_valid);
                    fail_count++;
                end
                if (interval_count !== x.cnt)
                begin
                    $error("interval_count exp %0d got %0d", x.cnt, interval_count);
                    fail_count++;
                end
                if (overflow !== x.ov)
                begin
                    $error("overflow exp %0b got %0b", x.ov, overflow);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        int unsigned f;
        int unsigned w;
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty table reads, extremes, empty range, splits.
        queue_read(0);
        queue_read(63);
        queue_insert(16'h0010, 16'h0005);         // empty range
        queue_insert(16'h0000, 16'hffff);         // whole code space
        queue_read(0);
        queue_insert(16'h1000, 16'h1fff);         // split middle
        queue_insert(16'h0000, 16'h0000);         // first code point alone
        queue_insert(16'hffff, 16'hffff);         // last code point alone
        queue_insert(16'h0800, 16'h17ff);         // straddles a boundary
        queue_insert(16'h1000, 16'h1fff);         // already aligned
        for (int i = 0; i < 6; i++)
        begin
            queue_read(i);
        end
        queue_read(5);
        queue_read(6);
        queue_read(63);
        queue_insert(16'hffff, 16'h0000);         // empty, extremes reversed
        queue_insert(16'h5555, 16'haaaa);

        // Random: mostly narrow inserts so the table fills and overflows,
        // plus reads across the full index range.
        for (int i = 0; i < 700; i++)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3:
                begin
                    queue_read($urandom_range(0, 63));
                end
                4:
                begin
                    queue_insert($urandom, $urandom);
                end
                default:
                begin
                    f = $urandom_range(0, 65535);
                    w = $urandom_range(0, 2047);
                    queue_insert(f, (f + w > 65535) ? 65535 : f + w);
                end
            endcase
        end

        wait (pending_cmds.size() == 0 && expected_resps.size() == 0 && !busy);
        repeat (300) @(posedge clk);
        $display("Covered %0d inserts (%0d rejected for room) and %0d reads.",
                 inserts_seen, overflows_seen, reads_seen);
        if (fail_count == 0 && expected_resps.size() == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
